// ===== hdl/mmwg_pkg.sv =====
// Package for the matrix multiply unit with forward and backward passes.
// Holds the command codes, register indexes, status codes and the packed transfer types.
// No dependencies.
package mmwg_pkg;

	// Command codes carried in the cmd field of an input transfer.
	typedef enum logic [2:0] {
		CMD_LOAD_A   = 3'd0,
		CMD_LOAD_B   = 3'd1,
		CMD_LOAD_DC  = 3'd2,
		CMD_FORWARD  = 3'd3,
		CMD_BACKWARD = 3'd4,
		CMD_READ_C   = 3'd5,
		CMD_READ_DA  = 3'd6,
		CMD_READ_DB  = 3'd7
	} cmd_t;

	// Configuration register indexes (byte address divided by four).
	localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
	localparam logic [1:0] REG_INNER_COUNT = 2'd1;
	localparam logic [1:0] REG_COL_COUNT   = 2'd2;

	// Status codes.
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// Width of a raw dimension register.
	localparam int unsigned CFG_W = 5;

	// One input transfer.
	typedef struct packed {
		cmd_t               cmd;
		logic [7:0]         elem_index;
		logic signed [31:0] elem_value;
	} item_t;

	// One result transfer.
	typedef struct packed {
		logic signed [31:0] read_value;
		logic               status;
	} result_t;

endpackage

// ===== hdl/matrix_multiply_with_gradients_unit.sv =====
// Top level of the matrix multiply unit: command handling, MAC sequencer, six element stores.
// Depends on mmwg_pkg and mmwg_ram.
//
// Loads and reads leave busy low: a new command may be started in the next cycle, and the
// result strobe rises in the cycle after the transfer. A forward command holds busy while
// it issues every product of C and while the pipeline drains; a backward command holds it
// through two passes, dA and then dB, and the same drain. Their length is set by the
// single multiply-accumulate pipeline, fed by one read port on each store and issuing one
// product per cycle. The result strobe of a forward or backward command marks completion,
// after which every written element is readable. The receiver cannot stall: each result
// is on the result port for exactly one cycle.
module matrix_multiply_with_gradients_unit #(
	parameter int unsigned MAX_DIM     = 16,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	// Command channel
	input  logic             start,
	output logic             busy,
	input  mmwg_pkg::item_t  item,
	output logic             result_valid,
	output mmwg_pkg::result_t result,
	// Configuration port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned VW       = VALUE_WIDTH;
	localparam int unsigned FRAC     = VALUE_WIDTH / 2;
	localparam int unsigned DEPTH    = MAX_DIM * MAX_DIM;
	localparam int unsigned ADDR_W   = $clog2(DEPTH);
	localparam int unsigned CNT_W    = $clog2(MAX_DIM);
	localparam int unsigned DIM_W    = $clog2(MAX_DIM + 1);
	localparam int unsigned PROD_W   = CNT_W + DIM_W;
	localparam int unsigned SIZE_W   = 2 * DIM_W;
	localparam int unsigned CMP_W    = (SIZE_W > 8) ? SIZE_W : 8;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	typedef enum logic [2:0] {
		PH_FWD = 3'b001,
		PH_DA  = 3'b010,
		PH_DB  = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_C    = 2'd1,
		SRC_DA   = 2'd2,
		SRC_DB   = 2'd3
	} src_t;

	// Row-major address: r * w + c.
	function automatic logic [ADDR_W-1:0] flat_addr(input logic [CNT_W-1:0] r,
			input logic [DIM_W-1:0] w, input logic [CNT_W-1:0] c);
		logic [PROD_W-1:0] sum;
		sum = PROD_W'(r) * PROD_W'(w) + PROD_W'(c);
		return ADDR_W'(sum);
	endfunction

	// Arithmetic shift back to the value format, then saturate.
	function automatic logic [VW-1:0] finish(input logic signed [63:0] acc);
		logic signed [63:0] sh;
		logic signed [63:0] v;
		sh = acc >>> FRAC;
		v = sh;
		if (sh > SAT_HI) begin
			v = SAT_HI;
		end else if (sh < SAT_LO) begin
			v = SAT_LO;
		end
		return VW'(v);
	endfunction

	// Clamp a raw dimension register to the range one to MAX_DIM.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [mmwg_pkg::CFG_W-1:0] raw);
		logic [DIM_W-1:0] d;
		if (raw == '0) begin
			d = DIM_W'(1);
		end else if (8'(raw) > 8'(MAX_DIM)) begin
			d = DIM_W'(MAX_DIM);
		end else begin
			d = DIM_W'(raw);
		end
		return d;
	endfunction

	// Configuration registers.
	logic [mmwg_pkg::CFG_W-1:0] row_count_q, inner_count_q, col_count_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= mmwg_pkg::CFG_W'(1);
			inner_count_q <= mmwg_pkg::CFG_W'(1);
			col_count_q   <= mmwg_pkg::CFG_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				mmwg_pkg::REG_ROW_COUNT:   row_count_q   <= pwdata[mmwg_pkg::CFG_W-1:0];
				mmwg_pkg::REG_INNER_COUNT: inner_count_q <= pwdata[mmwg_pkg::CFG_W-1:0];
				mmwg_pkg::REG_COL_COUNT:   col_count_q   <= pwdata[mmwg_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			mmwg_pkg::REG_ROW_COUNT:   prdata = 32'(row_count_q);
			mmwg_pkg::REG_INNER_COUNT: prdata = 32'(inner_count_q);
			mmwg_pkg::REG_COL_COUNT:   prdata = 32'(col_count_q);
			default:                   prdata = '0;
		endcase
	end

	// Effective dimensions and matrix sizes.
	logic [DIM_W-1:0]  rows, inner, cols;
	logic [SIZE_W-1:0] size_a, size_b, size_c;

	assign rows   = eff_dim(row_count_q);
	assign inner  = eff_dim(inner_count_q);
	assign cols   = eff_dim(col_count_q);
	assign size_a = SIZE_W'(rows) * SIZE_W'(inner);
	assign size_b = SIZE_W'(inner) * SIZE_W'(cols);
	assign size_c = SIZE_W'(rows) * SIZE_W'(cols);

	// Command decode.
	state_t state_q;
	phase_t phase_q;
	logic   accept;
	logic [SIZE_W-1:0] limit;
	logic   range_err;
	logic [ADDR_W-1:0] idx_addr;
	src_t   src_sel;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign idx_addr = ADDR_W'(item.elem_index);

	always_comb begin
		limit   = '0;
		src_sel = SRC_NONE;
		unique case (item.cmd)
			mmwg_pkg::CMD_LOAD_A:  limit = size_a;
			mmwg_pkg::CMD_LOAD_B:  limit = size_b;
			mmwg_pkg::CMD_LOAD_DC: limit = size_c;
			mmwg_pkg::CMD_READ_C: begin
				limit   = size_c;
				src_sel = SRC_C;
			end
			mmwg_pkg::CMD_READ_DA: begin
				limit   = size_a;
				src_sel = SRC_DA;
			end
			mmwg_pkg::CMD_READ_DB: begin
				limit   = size_b;
				src_sel = SRC_DB;
			end
			default: ;
		endcase
	end

	assign range_err = (item.cmd != mmwg_pkg::CMD_FORWARD)
		&& (item.cmd != mmwg_pkg::CMD_BACKWARD)
		&& (CMP_W'(item.elem_index) >= CMP_W'(limit));

	// Sequencer counters: outer, middle and inner loop.
	logic [CNT_W-1:0] o_q, m_q, n_q;
	logic [DIM_W-1:0] o_bound, m_bound, n_bound;
	logic last_o, last_m, last_n, last_issue;

	always_comb begin
		unique case (phase_q)
			PH_DA: begin
				o_bound = rows;
				m_bound = inner;
				n_bound = cols;
			end
			PH_DB: begin
				o_bound = inner;
				m_bound = cols;
				n_bound = rows;
			end
			default: begin
				o_bound = rows;
				m_bound = cols;
				n_bound = inner;
			end
		endcase
	end

	assign last_o     = (DIM_W'(o_q) == o_bound - DIM_W'(1));
	assign last_m     = (DIM_W'(m_q) == m_bound - DIM_W'(1));
	assign last_n     = (DIM_W'(n_q) == n_bound - DIM_W'(1));
	assign last_issue = last_o && last_m && last_n;

	// Pipeline valid flags.
	logic v_s1, v_s2, v_s3;
	logic pipe_busy;

	assign pipe_busy = v_s1 || v_s2 || v_s3;

	// Control state machine and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_FWD;
			o_q     <= '0;
			m_q     <= '0;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					o_q <= '0;
					m_q <= '0;
					n_q <= '0;
					if (accept && item.cmd == mmwg_pkg::CMD_FORWARD) begin
						state_q <= ST_RUN;
						phase_q <= PH_FWD;
					end else if (accept && item.cmd == mmwg_pkg::CMD_BACKWARD) begin
						state_q <= ST_RUN;
						phase_q <= PH_DA;
					end
				end
				ST_RUN: begin
					if (last_issue) begin
						o_q <= '0;
						m_q <= '0;
						n_q <= '0;
						if (phase_q == PH_DA) begin
							phase_q <= PH_DB;
						end else begin
							state_q <= ST_DRAIN;
						end
					end else if (last_n && last_m) begin
						n_q <= '0;
						m_q <= '0;
						o_q <= o_q + CNT_W'(1);
					end else if (last_n) begin
						n_q <= '0;
						m_q <= m_q + CNT_W'(1);
					end else begin
						n_q <= n_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Operand read addresses for the current step.
	logic [ADDR_W-1:0] a_raddr, b_raddr, dc_raddr, dest_addr;

	always_comb begin
		unique case (phase_q)
			PH_DA: begin
				a_raddr   = flat_addr(o_q, inner, n_q);
				b_raddr   = flat_addr(m_q, cols, n_q);
				dc_raddr  = flat_addr(o_q, cols, n_q);
				dest_addr = flat_addr(o_q, inner, m_q);
			end
			PH_DB: begin
				a_raddr   = flat_addr(n_q, inner, o_q);
				b_raddr   = flat_addr(n_q, cols, m_q);
				dc_raddr  = flat_addr(n_q, cols, m_q);
				dest_addr = flat_addr(o_q, cols, m_q);
			end
			default: begin
				a_raddr   = flat_addr(o_q, inner, n_q);
				b_raddr   = flat_addr(n_q, cols, m_q);
				dc_raddr  = flat_addr(o_q, cols, n_q);
				dest_addr = flat_addr(o_q, cols, m_q);
			end
		endcase
	end

	// Stores.
	logic [VW-1:0] a_rdata, b_rdata, dc_rdata, c_rdata, da_rdata, db_rdata;
	logic          load_ok;
	logic [VW-1:0] load_data;
	logic          wb_c, wb_da, wb_db;
	logic [VW-1:0] wb_data;
	logic [ADDR_W-1:0] dest_s3;

	assign load_ok   = accept && !range_err;
	assign load_data = item.elem_value[VW-1:0];

	mmwg_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_a_store (
		.clk(clk), .we(load_ok && item.cmd == mmwg_pkg::CMD_LOAD_A), .waddr(idx_addr),
		.wdata(load_data), .raddr(a_raddr), .rdata(a_rdata));
	mmwg_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_b_store (
		.clk(clk), .we(load_ok && item.cmd == mmwg_pkg::CMD_LOAD_B), .waddr(idx_addr),
		.wdata(load_data), .raddr(b_raddr), .rdata(b_rdata));
	mmwg_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_grad_out_store (
		.clk(clk), .we(load_ok && item.cmd == mmwg_pkg::CMD_LOAD_DC), .waddr(idx_addr),
		.wdata(load_data), .raddr(dc_raddr), .rdata(dc_rdata));
	mmwg_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_product_store (
		.clk(clk), .we(wb_c), .waddr(dest_s3),
		.wdata(wb_data), .raddr(idx_addr), .rdata(c_rdata));
	mmwg_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_grad_a_store (
		.clk(clk), .we(wb_da), .waddr(dest_s3),
		.wdata(wb_data), .raddr(idx_addr), .rdata(da_rdata));
	mmwg_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_grad_b_store (
		.clk(clk), .we(wb_db), .waddr(dest_s3),
		.wdata(wb_data), .raddr(idx_addr), .rdata(db_rdata));

	// MAC pipeline: stage 1 waits for the store read, stage 2 holds the product,
	// stage 3 holds the running sum and writes it back on the last term.
	logic              first_s1, last_s1, first_s2, last_s2, last_s3;
	logic [ADDR_W-1:0] dest_s1, dest_s2;
	phase_t            ph_s1, ph_s2, ph_s3;
	logic signed [VW-1:0]   x_s1, y_s1;
	logic signed [2*VW-1:0] prod_s2;
	logic signed [63:0]     acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (n_q == '0);
		last_s1  <= last_n;
		dest_s1  <= dest_addr;
		ph_s1    <= phase_q;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		dest_s2  <= dest_s1;
		ph_s2    <= ph_s1;
		prod_s2  <= x_s1 * y_s1;
		last_s3  <= last_s2;
		dest_s3  <= dest_s2;
		ph_s3    <= ph_s2;
		if (v_s2) begin
			acc_q <= (first_s2 ? 64'sd0 : acc_q) + 64'(prod_s2);
		end
	end

	// Operand selection by pass.
	always_comb begin
		unique case (ph_s1)
			PH_DA: begin
				x_s1 = $signed(dc_rdata);
				y_s1 = $signed(b_rdata);
			end
			PH_DB: begin
				x_s1 = $signed(a_rdata);
				y_s1 = $signed(dc_rdata);
			end
			default: begin
				x_s1 = $signed(a_rdata);
				y_s1 = $signed(b_rdata);
			end
		endcase
	end

	// Write-back of a finished sum.
	assign wb_data = finish(acc_q);
	assign wb_c    = v_s3 && last_s3 && (ph_s3 == PH_FWD);
	assign wb_da   = v_s3 && last_s3 && (ph_s3 == PH_DA);
	assign wb_db   = v_s3 && last_s3 && (ph_s3 == PH_DB);

	// Result transfer: loads and reads in the cycle after acceptance, passes at drain end.
	logic res_valid_q, res_err_q;
	src_t res_src_q;
	logic [VW-1:0] sel_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_err_q   <= mmwg_pkg::STATUS_OK;
			res_src_q   <= SRC_NONE;
		end else begin
			res_valid_q <= (accept && item.cmd != mmwg_pkg::CMD_FORWARD
				&& item.cmd != mmwg_pkg::CMD_BACKWARD)
				|| (state_q == ST_DRAIN && !pipe_busy);
			res_err_q   <= accept && range_err;
			res_src_q   <= (accept && !range_err) ? src_sel : SRC_NONE;
		end
	end

	always_comb begin
		unique case (res_src_q)
			SRC_C:   sel_rdata = c_rdata;
			SRC_DA:  sel_rdata = da_rdata;
			SRC_DB:  sel_rdata = db_rdata;
			default: sel_rdata = '0;
		endcase
	end

	assign result_valid      = res_valid_q;
	assign result.read_value = 32'($signed(sel_rdata));
	assign result.status     = res_err_q ? mmwg_pkg::STATUS_RANGE : mmwg_pkg::STATUS_OK;

	// A pass in flight always keeps the command channel closed.
	assert property (@(posedge clk) disable iff (!arst_n) pipe_busy |-> busy)
		else $error("MAC pipeline active while the unit reports idle");

	// A range error never returns data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status) |-> (result.read_value == 32'sd0))
		else $error("Out-of-range command returned a non-zero value");

	// A forward or backward transfer closes the channel in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.cmd == mmwg_pkg::CMD_FORWARD || item.cmd == mmwg_pkg::CMD_BACKWARD))
		|=> (busy && !result_valid))
		else $error("Pass command did not start the sequencer");

	// Write-back hits at most one result store.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0({wb_c, wb_da, wb_db}))
		else $error("Write-back to more than one store");

	// The drain ends with exactly one result transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && !pipe_busy) |=> (result_valid && !busy))
		else $error("Pass completed without a result transfer");

endmodule

// ===== hdl/mmwg_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for every element store of the matrix multiply unit. No dependencies.
module mmwg_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write first in the source order; a read of the same entry returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
